// File: hw/rtl/bezier_3d_point_and_derivative_macros.svh
// ----------------------------------------------------------------------------
// Bezier 3D evaluator assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef BEZIER_3D_POINT_AND_DERIVATIVE_MACROS_SVH
`define BEZIER_3D_POINT_AND_DERIVATIVE_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define BZ_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define BZ_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BZ_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define BZ_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// File: hw/rtl/bz3_pkg.sv
// ----------------------------------------------------------------------------
// bz3_pkg
// Shared types and codes of the Bezier 3D point and derivative evaluator.
// ----------------------------------------------------------------------------
package bz3_pkg;

   localparam logic [1:0] FUNC_LOAD  = 2'd0;
   localparam logic [1:0] FUNC_POINT = 2'd1;
   localparam logic [1:0] FUNC_DERIV = 2'd2;
   localparam logic [1:0] FUNC_NONE  = 2'd3;

   localparam logic [1:0] CSR_POINT_COUNT = 2'd0;
   localparam logic [1:0] CSR_START       = 2'd1;
   localparam logic [1:0] CSR_INV_WIDTH   = 2'd2;

   localparam int          FRAC_BITS = 16;
   localparam logic [16:0] ONE_Q16   = 17'd65536;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_MUL,
      ST_INIT,
      ST_MULT,
      ST_STEP,
      ST_SCALE,
      ST_OUT
   } state_type;

   // per-cell control
   typedef struct packed {
      logic load;
      logic init_point;
      logic init_diff;
      logic shift;
      logic tail;
   } cell_ctrl_type;

endpackage

// File: hw/rtl/bezier_3d_point_and_derivative.sv
// ----------------------------------------------------------------------------
// bezier_3d_point_and_derivative
// Fixed-point 3D Bezier point and derivative evaluator over a cell chain.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one request: func in req_tuser selects a control point
//   load, a curve point or a derivative. A load writes one slot in the
//   cycle it is accepted and gives no response. Point and derivative
//   requests give one response on rsp_ (x, y, z saturated Q16.16, error
//   flag in rsp_tuser).
//   The control points sit in a chain of cells. Evaluation runs the
//   de Casteljau ladder by shifting the working values one cell per step
//   past three shared blend units (one per coordinate) at the head; each
//   step is a multiply, then an add and shift, and a level of length m
//   takes m steps. One request is in work at a time, and req_tready is
//   high only while idle.
//   Reset clears the control path and the registers to their defaults;
//   point slots are undefined until loaded. If the receiver stalls, the
//   response holds in the output register and the next request may still
//   be taken; a finished result then waits until the register frees.
// ----------------------------------------------------------------------------
`include "bezier_3d_point_and_derivative_macros.svh"

module bezier_3d_point_and_derivative import bz3_pkg::*; #(
   parameter int MAX_POINTS  = 16,
   parameter int COORD_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // point_index[3:0], in_x[35:4], in_y[67:36], in_z[99:68],
   // param_u[131:100], zero pad[135:132]
   input  logic [135:0] req_tdata,
   // func[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // res_x[31:0], res_y[63:32], res_z[95:64]
   output logic [95:0]  rsp_tdata,
   // error_flag[0]
   output logic [0:0]   rsp_tuser,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   localparam int WW = COORD_WIDTH + 1;
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int PW = WW + CW + 1;
   localparam int SW = (PW > 33) ? PW : 33;
   localparam logic signed [SW-1:0] SAT_HI = SW'(64'sh7FFF_FFFF);
   localparam logic signed [SW-1:0] SAT_LO = SW'(-64'sh8000_0000);

   // request fields
   logic [3:0]         req_point_index;
   logic signed [31:0] req_in_x, req_in_y, req_in_z, req_param_u;
   logic [1:0]         req_func;

   assign req_point_index = req_tdata[3:0];
   assign req_in_x        = req_tdata[35:4];
   assign req_in_y        = req_tdata[67:36];
   assign req_in_z        = req_tdata[99:68];
   assign req_param_u     = req_tdata[131:100];
   assign req_func        = req_tuser;

   // configuration
   logic [4:0]         pc_ff;
   logic signed [31:0] start_ff;
   logic [31:0]        inv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff    <= 5'd1;
         start_ff <= '0;
         inv_ff   <= 32'd65536;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_POINT_COUNT: pc_ff    <= csr_wdata[4:0];
            CSR_START:       start_ff <= csr_wdata;
            CSR_INV_WIDTH:   inv_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // control state
   state_type state_ff, state_in;
   logic      deriv_ff, zero_ff, err_ff;
   logic [CW-1:0] m_ff, k_ff, mult_ff;
   logic signed [31:0] pu_ff;
   logic signed [32:0] d_ff;
   logic [63:0]        prod_ff;
   logic [16:0]        u_ff;
   logic               rsp_valid_ff;
   logic [95:0]        rsp_data_ff;
   logic               rsp_err_ff;

   logic req_acc, out_free, eval_req;
   logic [CW-1:0] n_sat, m_init;
   logic seed_point, seed_diff, seed_zero, seed_err;
   logic step_last;

   assign req_acc   = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign eval_req  = (req_func == FUNC_POINT) || (req_func == FUNC_DERIV);
   assign n_sat     = (32'(pc_ff) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(pc_ff);
   assign step_last = (k_ff == m_ff - CW'(1));

   // ladder seed: derivative runs over n-1 differences
   always_comb begin
      seed_point = 1'b0;
      seed_diff  = 1'b0;
      seed_zero  = 1'b0;
      seed_err   = 1'b0;
      m_init     = n_sat;
      if (deriv_ff) begin
         if (n_sat < CW'(2)) begin
            seed_zero = 1'b1;
            seed_err  = 1'b1;
            m_init    = '0;
         end else begin
            seed_diff = 1'b1;
            m_init    = n_sat - CW'(1);
         end
      end else begin
         seed_point = 1'b1;
         seed_zero  = (n_sat == '0);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_acc && eval_req) state_in = ST_DIFF;
         ST_DIFF:  state_in = ST_MUL;
         ST_MUL:   state_in = ST_INIT;
         ST_INIT:  state_in = (m_init <= CW'(1)) ? ST_SCALE : ST_MULT;
         ST_MULT:  state_in = ST_STEP;
         ST_STEP: begin
            if (step_last && m_ff == CW'(2)) state_in = ST_SCALE;
            else                            state_in = ST_MULT;
         end
         ST_SCALE: state_in = ST_OUT;
         ST_OUT:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   cell_ctrl_type ctrl_base;
   logic do_load, do_step, do_init, do_out;

   always_comb begin
      req_tready = 1'b0;
      do_load    = 1'b0;
      do_step    = 1'b0;
      do_init    = 1'b0;
      do_out     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            do_load    = req_tvalid && (req_func == FUNC_LOAD);
         end
         ST_INIT:  do_init = 1'b1;
         ST_STEP:  do_step = 1'b1;
         ST_OUT:   do_out  = out_free;
         default: ;
      endcase
      ctrl_base            = '0;
      ctrl_base.init_point = do_init && seed_point;
      ctrl_base.init_diff  = do_init && seed_diff;
      ctrl_base.shift      = do_step;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // localize the parameter: subtract, multiply, clamp
   always_ff @(posedge clock) begin
      if (req_acc) begin
         pu_ff    <= req_param_u;
         deriv_ff <= (req_func == FUNC_DERIV);
      end
      if (state_ff == ST_DIFF) d_ff <= 33'(pu_ff) - 33'(start_ff);
      if (state_ff == ST_MUL)  prod_ff <= 64'(d_ff[31:0]) * 64'(inv_ff);
      if (do_init) begin
         if (d_ff <= 33'sd0)                        u_ff <= '0;
         else if (prod_ff[63:16] > 48'(ONE_Q16))    u_ff <= ONE_Q16;
         else                                       u_ff <= prod_ff[32:16];
         zero_ff <= seed_zero;
         err_ff  <= seed_err;
         mult_ff <= deriv_ff ? m_init : CW'(1);
      end
   end

   // ladder counters
   always_ff @(posedge clock) begin
      if (reset) begin
         m_ff <= '0;
         k_ff <= '0;
      end else if (do_init) begin
         m_ff <= m_init;
         k_ff <= '0;
      end else if (do_step) begin
         if (step_last) begin
            m_ff <= m_ff - CW'(1);
            k_ff <= '0;
         end else begin
            k_ff <= k_ff + CW'(1);
         end
      end
   end

   // load data is sign-extended to COORD_WIDTH bits, or keeps its low COORD_WIDTH bits when narrower
   logic signed [COORD_WIDTH-1:0] ld_x, ld_y, ld_z;

   generate
      if (COORD_WIDTH >= 32) begin : g_ld_wide
         assign ld_x = COORD_WIDTH'(req_in_x);
         assign ld_y = COORD_WIDTH'(req_in_y);
         assign ld_z = COORD_WIDTH'(req_in_z);
      end else begin : g_ld_narrow
         assign ld_x = req_in_x[COORD_WIDTH-1:0];
         assign ld_y = req_in_y[COORD_WIDTH-1:0];
         assign ld_z = req_in_z[COORD_WIDTH-1:0];
      end
   endgenerate

   // cell chain
   logic signed [COORD_WIDTH-1:0] sx [MAX_POINTS+1];
   logic signed [COORD_WIDTH-1:0] sy [MAX_POINTS+1];
   logic signed [COORD_WIDTH-1:0] sz [MAX_POINTS+1];
   logic signed [WW-1:0]          wx [MAX_POINTS+1];
   logic signed [WW-1:0]          wy [MAX_POINTS+1];
   logic signed [WW-1:0]          wz [MAX_POINTS+1];
   logic signed [WW-1:0]          lx, ly, lz;

   // the slot past the end feeds zeros into the last cell
   assign sx[MAX_POINTS] = '0;
   assign sy[MAX_POINTS] = '0;
   assign sz[MAX_POINTS] = '0;
   assign wx[MAX_POINTS] = '0;
   assign wy[MAX_POINTS] = '0;
   assign wz[MAX_POINTS] = '0;

   genvar j;
   generate
      for (j = 0; j < MAX_POINTS; j++) begin : g_cell
         cell_ctrl_type ctrl;

         always_comb begin
            ctrl       = ctrl_base;
            ctrl.load  = do_load && (32'(req_point_index) == j);
            ctrl.shift = ctrl_base.shift && (32'(m_ff) > j);
            ctrl.tail  = (32'(m_ff) == j + 1);
         end

         bz3_cell #(.COORD_WIDTH(COORD_WIDTH)) u_cell (
            .clock  (clock),
            .ctrl   (ctrl),
            .ld_x   (ld_x),
            .ld_y   (ld_y),
            .ld_z   (ld_z),
            .nxt_sx (sx[j+1]),
            .nxt_sy (sy[j+1]),
            .nxt_sz (sz[j+1]),
            .nxt_wx (wx[j+1]),
            .nxt_wy (wy[j+1]),
            .nxt_wz (wz[j+1]),
            .lerp_x (lx),
            .lerp_y (ly),
            .lerp_z (lz),
            .sx     (sx[j]),
            .sy     (sy[j]),
            .sz     (sz[j]),
            .wx     (wx[j]),
            .wy     (wy[j]),
            .wz     (wz[j])
         );
      end
   endgenerate

   // blend units at the head of the chain
   bz3_lerp #(.COORD_WIDTH(COORD_WIDTH)) u_lerp_x (
      .clock(clock), .u(u_ff), .a(wx[0]), .b(wx[1]), .result(lx));
   bz3_lerp #(.COORD_WIDTH(COORD_WIDTH)) u_lerp_y (
      .clock(clock), .u(u_ff), .a(wy[0]), .b(wy[1]), .result(ly));
   bz3_lerp #(.COORD_WIDTH(COORD_WIDTH)) u_lerp_z (
      .clock(clock), .u(u_ff), .a(wz[0]), .b(wz[1]), .result(lz));

   // scale by the degree (derivative) and saturate, one coordinate per lane
   logic signed [PW-1:0] scale_in [3];
   logic signed [31:0]   sat_res  [3];
   logic signed [WW-1:0] head     [3];
   logic [1:0]           lane_sel [3];

   assign head[0] = wx[0];
   assign head[1] = wy[0];
   assign head[2] = wz[0];

   logic signed [PW-1:0] scale_x_ff, scale_y_ff, scale_z_ff;

   genvar c;
   generate
      for (c = 0; c < 3; c++) begin : g_lane
         logic signed [SW-1:0] wide;
         assign lane_sel[c] = 2'(c);
         assign scale_in[c] = zero_ff ? '0
                              : PW'(head[c]) * PW'($signed({1'b0, mult_ff}));
         always_comb begin
            unique case (lane_sel[c])
               2'd0:    wide = SW'(scale_x_ff);
               2'd1:    wide = SW'(scale_y_ff);
               default: wide = SW'(scale_z_ff);
            endcase
            if (wide > SAT_HI)      sat_res[c] = 32'sh7FFF_FFFF;
            else if (wide < SAT_LO) sat_res[c] = 32'sh8000_0000;
            else                    sat_res[c] = wide[31:0];
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (state_ff == ST_SCALE) begin
         scale_x_ff <= scale_in[0];
         scale_y_ff <= scale_in[1];
         scale_z_ff <= scale_in[2];
      end
   end

   // output register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (do_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (do_out) begin
         rsp_data_ff <= {sat_res[2], sat_res[1], sat_res[0]};
         rsp_err_ff  <= err_ff;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_err_ff;

   // ladder only steps over at least two live values
   `BZ_ASSERT_IMPL(a_step_len, clock, reset, state_ff == ST_STEP, m_ff >= CW'(2), "ladder step with fewer than two values")
   // localized parameter stays within the unit interval
   `BZ_ASSERT_IMPL(a_u_range, clock, reset, state_ff == ST_MULT, u_ff <= ONE_Q16, "parameter above one")
   // an error response carries zero coordinates
   `BZ_ASSERT_IMPL(a_err_zero, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata == '0, "error response with data")
   // an evaluate request blocks further requests until done
   `BZ_ASSERT_NXT(a_busy, clock, reset, req_acc && eval_req, !req_tready, "request taken while busy")

endmodule

// File: hw/rtl/bz3_cell.sv
// ----------------------------------------------------------------------------
// bz3_cell
// One control point slot with its working value for the de Casteljau ladder.
// ----------------------------------------------------------------------------
module bz3_cell import bz3_pkg::*; #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  cell_ctrl_type                 ctrl,
   input  logic signed [COORD_WIDTH-1:0] ld_x,
   input  logic signed [COORD_WIDTH-1:0] ld_y,
   input  logic signed [COORD_WIDTH-1:0] ld_z,
   input  logic signed [COORD_WIDTH-1:0] nxt_sx,
   input  logic signed [COORD_WIDTH-1:0] nxt_sy,
   input  logic signed [COORD_WIDTH-1:0] nxt_sz,
   input  logic signed [COORD_WIDTH:0]   nxt_wx,
   input  logic signed [COORD_WIDTH:0]   nxt_wy,
   input  logic signed [COORD_WIDTH:0]   nxt_wz,
   input  logic signed [COORD_WIDTH:0]   lerp_x,
   input  logic signed [COORD_WIDTH:0]   lerp_y,
   input  logic signed [COORD_WIDTH:0]   lerp_z,
   output logic signed [COORD_WIDTH-1:0] sx,
   output logic signed [COORD_WIDTH-1:0] sy,
   output logic signed [COORD_WIDTH-1:0] sz,
   output logic signed [COORD_WIDTH:0]   wx,
   output logic signed [COORD_WIDTH:0]   wy,
   output logic signed [COORD_WIDTH:0]   wz
);

   localparam int WW = COORD_WIDTH + 1;

   logic signed [COORD_WIDTH-1:0] sx_ff, sy_ff, sz_ff;
   logic signed [WW-1:0]          wx_ff, wy_ff, wz_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         sx_ff <= ld_x;
         sy_ff <= ld_y;
         sz_ff <= ld_z;
      end
   end

   // working value: seed from the slot, then advance along the chain
   always_ff @(posedge clock) begin
      if (ctrl.init_point) begin
         wx_ff <= WW'(sx_ff);
         wy_ff <= WW'(sy_ff);
         wz_ff <= WW'(sz_ff);
      end else if (ctrl.init_diff) begin
         wx_ff <= WW'(nxt_sx) - WW'(sx_ff);
         wy_ff <= WW'(nxt_sy) - WW'(sy_ff);
         wz_ff <= WW'(nxt_sz) - WW'(sz_ff);
      end else if (ctrl.shift) begin
         if (ctrl.tail) begin
            wx_ff <= lerp_x;
            wy_ff <= lerp_y;
            wz_ff <= lerp_z;
         end else begin
            wx_ff <= nxt_wx;
            wy_ff <= nxt_wy;
            wz_ff <= nxt_wz;
         end
      end
   end

   assign sx = sx_ff;
   assign sy = sy_ff;
   assign sz = sz_ff;
   assign wx = wx_ff;
   assign wy = wy_ff;
   assign wz = wz_ff;

endmodule

// File: hw/rtl/bz3_lerp.sv
// ----------------------------------------------------------------------------
// bz3_lerp
// Registered linear blend a + floor(u * (b - a) / 2^16), one coordinate.
// ----------------------------------------------------------------------------
module bz3_lerp import bz3_pkg::*; #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                        clock,
   input  logic [16:0]                 u,
   input  logic signed [COORD_WIDTH:0] a,
   input  logic signed [COORD_WIDTH:0] b,
   output logic signed [COORD_WIDTH:0] result
);

   localparam int WW = COORD_WIDTH + 1;
   localparam int PW = WW + 19;

   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [WW-1:0] a_ff;
   logic signed [WW:0]   diff;

   assign diff    = (WW + 1)'(b) - (WW + 1)'(a);
   assign prod_in = PW'($signed({1'b0, u})) * PW'(diff);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      a_ff    <= a;
   end

   assign result = a_ff + WW'(prod_ff >>> FRAC_BITS);

endmodule

// File: tb/bezier_result_checker.sv
// ----------------------------------------------------------------------------
// bezier_result_checker
// Watches the request, response and register ports of the Bezier evaluator,
// predicts each curve point or derivative and compares responses in order.
// ----------------------------------------------------------------------------
module bezier_result_checker import bz3_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [135:0] req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [95:0]  rsp_tdata,
   input  logic [0:0]   rsp_tuser,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata,
   output int           pending,
   output int           failures
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = 16;

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic        err;
   } curve_result_type;

   curve_result_type expected_results[$];

   logic [4:0]  count_reg;
   longint      start_reg;
   logic [31:0] inv_width_reg;
   longint      slot_x[SLOTS];
   longint      slot_y[SLOTS];
   longint      slot_z[SLOTS];

   initial failures = 0;
   assign pending = expected_results.size();

   function automatic longint blend(longint a, longint b, longint u);
      longint d;
      longint hi;
      longint lo;
      if (u >= 65536) return b;
      d  = b - a;
      hi = d >>> FRAC_BITS;
      lo = d - hi * 65536;
      return a + u * hi + (u * lo) / 65536;
   endfunction

   function automatic longint ladder(longint w[SLOTS], int n, longint u);
      for (int i = 1; i < n; i++)
         for (int j = 0; j + i < n; j++)
            w[j] = blend(w[j], w[j + 1], u);
      return w[0];
   endfunction

   function automatic logic [31:0] clip32(longint v);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
   endfunction

   function automatic longint local_param(logic [31:0] pu);
      longint      d;
      logic [63:0] p;
      d = longint'($signed(pu)) - start_reg;
      if (d <= 0) return 0;
      // both factors are below 2^32, so the product fits in 64 bits
      p = (64'(d) * 64'(inv_width_reg)) >> FRAC_BITS;
      if (p > 64'd65536) p = 64'd65536;
      return longint'(p);
   endfunction

   function automatic curve_result_type predict_curve(logic [1:0] func, logic [31:0] pu);
      curve_result_type r;
      int            n;
      longint        u;
      longint        wx[SLOTS];
      longint        wy[SLOTS];
      longint        wz[SLOTS];
      longint        rx;
      longint        ry;
      longint        rz;
      rx = 0; ry = 0; rz = 0;
      r.err = 1'b0;
      n = (count_reg > SLOTS) ? SLOTS : int'(count_reg);
      u = local_param(pu);
      for (int i = 0; i < SLOTS; i++) begin
         wx[i] = 0; wy[i] = 0; wz[i] = 0;
      end
      if (func == FUNC_POINT) begin
         if (n > 0) begin
            for (int i = 0; i < n; i++) begin
               wx[i] = slot_x[i]; wy[i] = slot_y[i]; wz[i] = slot_z[i];
            end
            rx = ladder(wx, n, u);
            ry = ladder(wy, n, u);
            rz = ladder(wz, n, u);
         end
      end else if (n < 2) begin
         r.err = 1'b1;
      end else begin
         for (int i = 0; i < n - 1; i++) begin
            wx[i] = slot_x[i + 1] - slot_x[i];
            wy[i] = slot_y[i + 1] - slot_y[i];
            wz[i] = slot_z[i + 1] - slot_z[i];
         end
         rx = ladder(wx, n - 1, u) * (n - 1);
         ry = ladder(wy, n - 1, u) * (n - 1);
         rz = ladder(wz, n - 1, u) * (n - 1);
      end
      r.x = clip32(rx);
      r.y = clip32(ry);
      r.z = clip32(rz);
      return r;
   endfunction

   always @(posedge clock) begin
      curve_result_type want;
      logic [3:0]    idx;
      if (reset) begin
         count_reg     = 5'd1;
         start_reg     = 0;
         inv_width_reg = 32'd65536;
         expected_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_POINT_COUNT: count_reg     = csr_wdata[4:0];
               CSR_START:       start_reg     = longint'($signed(csr_wdata));
               CSR_INV_WIDTH:   inv_width_reg = csr_wdata;
               default: ;
            endcase
         end
         // check the response leaving before taking any new request
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               failures++;
               $display("%0t: response expected none actual %h err %b", $time, rsp_tdata,
                        rsp_tuser);
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata[31:0] !== want.x) begin
                  failures++;
                  $display("%0t: res_x expected %h actual %h", $time, want.x, rsp_tdata[31:0]);
               end
               if (rsp_tdata[63:32] !== want.y) begin
                  failures++;
                  $display("%0t: res_y expected %h actual %h", $time, want.y, rsp_tdata[63:32]);
               end
               if (rsp_tdata[95:64] !== want.z) begin
                  failures++;
                  $display("%0t: res_z expected %h actual %h", $time, want.z, rsp_tdata[95:64]);
               end
               if (rsp_tuser[0] !== want.err) begin
                  failures++;
                  $display("%0t: error_flag expected %b actual %b", $time, want.err, rsp_tuser[0]);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               FUNC_LOAD: begin
                  idx = req_tdata[3:0];
                  slot_x[idx] = longint'($signed(req_tdata[35:4]));
                  slot_y[idx] = longint'($signed(req_tdata[67:36]));
                  slot_z[idx] = longint'($signed(req_tdata[99:68]));
               end
               FUNC_POINT, FUNC_DERIV:
                  expected_results.push_back(predict_curve(req_tuser, req_tdata[131:100]));
               default: ;
            endcase
         end
      end
   end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the Bezier point and derivative evaluator: directed corner
// requests, then random loads and evaluations under three idling patterns.
// ----------------------------------------------------------------------------
module testbench import bz3_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 3000000;
   localparam int SETTLE       = 320;   // longest evaluation plus margin
   localparam int PHASE_ITEMS  = 650;
   localparam int CSR_INTERVAL = 130;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [135:0] req_tdata = '0;
   logic [1:0]   req_tuser = FUNC_LOAD;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         csr_we = 1'b0;
   logic [1:0]   csr_index = CSR_POINT_COUNT;
   logic [31:0]  csr_wdata = '0;

   int pending;
   int failures;
   int send_idle = 0;   // percent of requests preceded by a gap
   int recv_idle = 0;   // percent of cycles the receiver stalls
   int cycles = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   bezier_3d_point_and_derivative dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   bezier_result_checker checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .pending(pending), .failures(failures)
   );

   // receiver stalls at random, at the rate of the current phase
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle);

   // guard against a hung block
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // present one request and hold it until the block takes it
   task automatic send_request(logic [1:0] func, logic [3:0] idx, logic [31:0] x,
                               logic [31:0] y, logic [31:0] z, logic [31:0] pu);
      logic taken;
      if ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {4'b0, pu, z, y, x, idx};
      // sample ready at the falling edge ahead of the edge that would take it
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
   endtask

   // drop valid, wait for every response, then let the block settle
   task automatic drain;
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // write one register, then drop the write enable before the next drive
   task automatic write_reg(logic [1:0] index, logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord;
      case ($urandom_range(9))
         0:       return 32'h7fff_ffff;
         1:       return 32'h8000_0000;
         2, 3, 4: return $urandom;
         default: return 32'($signed($urandom_range(2000000)) - 1000000);
      endcase
   endfunction

   // mostly small counts keep the run short; a few reach the extremes
   task automatic random_setting;
      logic [31:0] cnt;
      case ($urandom_range(19))
         0:       cnt = 0;
         1:       cnt = 16;
         2:       cnt = $urandom_range(17, 31);
         3:       cnt = $urandom_range(7, 15);
         default: cnt = $urandom_range(1, 6);
      endcase
      write_reg(CSR_POINT_COUNT, cnt);
      case ($urandom_range(5))
         0:       write_reg(CSR_START, 32'h8000_0000);
         1:       write_reg(CSR_START, 32'h7fff_ffff);
         2:       write_reg(CSR_START, $urandom);
         default: write_reg(CSR_START, 32'($signed($urandom_range(131072)) - 65536));
      endcase
      case ($urandom_range(5))
         0:       write_reg(CSR_INV_WIDTH, 32'd0);
         1:       write_reg(CSR_INV_WIDTH, 32'hffff_ffff);
         2:       write_reg(CSR_INV_WIDTH, $urandom);
         default: write_reg(CSR_INV_WIDTH, $urandom_range(16384, 262144));
      endcase
   endtask

   task automatic random_request;
      logic [31:0] pu;
      pu = ($urandom_range(3) == 0) ? $urandom : 32'($signed($urandom_range(196608)) - 65536);
      case ($urandom_range(19))
         0:                      send_request(FUNC_NONE, 4'($urandom), $urandom, $urandom,
                                              $urandom, $urandom);
         1, 2, 3, 4, 5, 6, 7:    send_request(FUNC_LOAD, 4'($urandom), rand_coord(),
                                              rand_coord(), rand_coord(), $urandom);
         8, 9, 10, 11, 12, 13:   send_request(FUNC_POINT, 4'($urandom), $urandom, $urandom,
                                              $urandom, pu);
         default:                send_request(FUNC_DERIV, 4'($urandom), $urandom, $urandom,
                                              $urandom, pu);
      endcase
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle = 32;
      recv_idle = 59;

      // fill every slot first so that no evaluation reads an empty one
      for (int i = 0; i < 16; i++) begin
         case (i % 4)
            0:       send_request(FUNC_LOAD, 4'(i), 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0);
            1:       send_request(FUNC_LOAD, 4'(i), 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
                                  32'h0);
            default: send_request(FUNC_LOAD, 4'(i), $urandom, $urandom, $urandom, 32'h0);
         endcase
      end
      // default setting: one point
      send_request(FUNC_POINT, 4'h0, '0, '0, '0, 32'h0000_8000);
      send_request(FUNC_DERIV, 4'h0, '0, '0, '0, 32'h0000_8000);   // too few points
      send_request(FUNC_NONE, 4'hf, '1, '1, '1, '1);               // ignored
      drain();
      write_reg(CSR_POINT_COUNT, 32'd31);                           // clips to full store
      send_request(FUNC_POINT, 4'h0, '0, '0, '0, 32'h8000_0000);   // below interval
      send_request(FUNC_POINT, 4'h0, '0, '0, '0, 32'h0000_8000);
      send_request(FUNC_POINT, 4'h0, '0, '0, '0, 32'h7fff_ffff);   // clamps to one
      send_request(FUNC_DERIV, 4'h0, '0, '0, '0, 32'h0000_4000);   // saturating derivative
      send_request(FUNC_DERIV, 4'h0, '0, '0, '0, 32'h0001_0000);
      drain();
      write_reg(CSR_POINT_COUNT, 32'd0);
      write_reg(CSR_START, 32'h8000_0000);
      write_reg(CSR_INV_WIDTH, 32'hffff_ffff);
      send_request(FUNC_POINT, 4'h0, '0, '0, '0, 32'h7fff_ffff);   // no points in use
      send_request(FUNC_DERIV, 4'h0, '0, '0, '0, 32'h0000_0000);
      drain();
      write_reg(CSR_POINT_COUNT, 32'd16);
      write_reg(CSR_START, 32'h7fff_ffff);
      write_reg(CSR_INV_WIDTH, 32'd0);
      send_request(FUNC_POINT, 4'h0, '0, '0, '0, 32'h8000_0000);
      send_request(FUNC_DERIV, 4'h0, '0, '0, '0, 32'h7fff_ffff);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0:       begin send_idle = 32; recv_idle = 59; end
            1:       begin send_idle = 59; recv_idle = 32; end
            default: begin send_idle = 0;  recv_idle = 0;  end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % CSR_INTERVAL == 0) begin
               drain();
               random_setting();
            end
            random_request();
         end
      end

      drain();
      if (failures == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
